// ===== rtl/pfsc_pkg.sv =====
package pfsc_pkg;

  localparam int unsigned MIN_INTERVAL_MS_DEF       = 10;
  localparam int unsigned INTEGRAL_LIMIT_RPM_MS_DEF = 50000;

  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 16;
  localparam int TIME_W  = 32;
  localparam int DUTY_W  = 8;
  localparam int ERR_W   = 17;
  localparam int DERR_W  = 18;
  localparam int MAG_W   = 17;
  localparam int PROD_W  = 2 * TIME_W;
  localparam int INTW_W  = PROD_W + 1;
  localparam int NUM_W   = 42;
  localparam int SUM_W   = 44;
  localparam int ACC_W   = 24;
  localparam int ACCX_W  = SUM_W + 1;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int SHIFT_W = $clog2(PROD_W);
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [GAIN_W-1:0]  KP_RESET     = 16'd2048;
  localparam logic [GAIN_W-1:0]  KI_RESET     = 16'd819;
  localparam logic [GAIN_W-1:0]  KD_RESET     = 16'd205;
  localparam logic [SPEED_W-1:0] TARGET_RESET = 16'd1500;

  localparam logic [7:0] PI_SCALE = 8'd51;
  localparam logic [7:0] D_SCALE  = 8'd204;

  localparam logic [TIME_W-1:0] P_DIVISOR = 32'd250;
  localparam logic [TIME_W-1:0] I_DIVISOR = 32'd250000;

  // gain*mag / 250: halve, then multiply by ceil(2^38/125)
  localparam logic [SHIFT_W-1:0] P_PRE_SHIFT  = 6'd1;
  localparam logic [TIME_W-1:0]  P_RCP        = 32'd2199023256;
  localparam logic [SHIFT_W-1:0] P_RCP_SHIFT  = 6'd38;
  // (51*rem + 125) / 250 with rem below 250
  localparam logic [TIME_W-1:0]  P_FRAC_RCP   = 32'd16778;
  localparam logic [SHIFT_W-1:0] P_FRAC_SHIFT = 6'd22;

  // gain*mag / 250000: divide by 16, then multiply by ceil(2^42/15625)
  localparam logic [SHIFT_W-1:0] I_PRE_SHIFT  = 6'd4;
  localparam logic [TIME_W-1:0]  I_RCP        = 32'd281474977;
  localparam logic [SHIFT_W-1:0] I_RCP_SHIFT  = 6'd42;
  // (51*rem + 125000) / 250000 with rem below 250000
  localparam logic [TIME_W-1:0]  I_FRAC_RCP   = 32'd17592187;
  localparam logic [SHIFT_W-1:0] I_FRAC_SHIFT = 6'd42;

  localparam logic [DUTY_W-1:0] DUTY_MIN   = 8'd60;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd128;

  localparam logic [ACC_W-1:0] ACC_MIN   = {DUTY_MIN, 16'd0};
  localparam logic [ACC_W-1:0] ACC_MAX   = {DUTY_MAX, 16'd0};
  localparam logic [ACC_W-1:0] ACC_RESET = {DUTY_RESET, 16'd0};

  typedef enum logic [1:0] {
    REG_KP     = 2'd0,
    REG_KI     = 2'd1,
    REG_KD     = 2'd2,
    REG_TARGET = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_INT,
    ST_INTEG,
    ST_MUL_GAIN,
    ST_MUL_MAG,
    ST_DIV_LOAD,
    ST_DIV,
    ST_RCP_QUO,
    ST_RCP_REM,
    ST_RCP_SCALE,
    ST_RCP_FRAC,
    ST_RCP_WHOLE,
    ST_ACC,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/pid_fan_speed_controller.sv =====
// channel   signals                                      beat
// in        in_valid in_ready measured_speed time_now_ms  one speed sample
// out       out_valid out_ready duty updated             one duty result
// cfg       psel penable pwrite paddr pwdata prdata      one register write or read
//
// a skipped sample (interval too short) goes from the check state straight to the emit state
// in an update, the proportional and integral terms divide by their
// constants with reciprocal multiplies on the shared 32x32 multiplier;
// the derivative term divides by the elapsed time one bit per cycle
// rst is synchronous; it restores gains, setpoint, integral, error and duty 128
// a finished result waits in the output register; the next sample is taken meanwhile
module pid_fan_speed_controller #(
  parameter int unsigned MIN_INTERVAL_MS       = pfsc_pkg::MIN_INTERVAL_MS_DEF,
  parameter int unsigned INTEGRAL_LIMIT_RPM_MS = pfsc_pkg::INTEGRAL_LIMIT_RPM_MS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pfsc_pkg::SPEED_W-1:0]   measured_speed,
  input  logic [pfsc_pkg::TIME_W-1:0]    time_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pfsc_pkg::DUTY_W-1:0]    duty,
  output logic                           updated,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfsc_pkg::ADDR_W-1:0]    paddr,
  input  logic [pfsc_pkg::DATA_W-1:0]    pwdata,
  output logic [pfsc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import pfsc_pkg::*;

  localparam logic signed [INTW_W-1:0] INT_LIM = INTW_W'(INTEGRAL_LIMIT_RPM_MS);

  state_t state, state_next;
  term_t  term;

  logic [GAIN_W-1:0]  kp, ki, kd;
  logic [SPEED_W-1:0] target;

  logic [TIME_W-1:0]        last_time;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ERR_W-1:0]  err_int;
  logic [ACC_W-1:0]         dacc;

  logic [TIME_W-1:0]        now_q;
  logic [TIME_W-1:0]        dt;
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         num;
  logic [TIME_W-1:0]        rem;
  logic [TIME_W-1:0]        divisor;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic signed [SUM_W-1:0]  sum;
  logic                     upd;

  logic [TIME_W-1:0]  mul_a;
  logic [TIME_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [GAIN_W-1:0]  t_gain;
  logic [7:0]         t_scale;
  logic [MAG_W-1:0]   t_mag;
  logic               t_neg;
  logic [TIME_W-1:0]  t_div;
  logic [SHIFT_W-1:0] t_pre;
  logic [TIME_W-1:0]  t_rcp;
  logic [SHIFT_W-1:0] t_post;
  logic [TIME_W-1:0]  t_frac_rcp;
  logic [SHIFT_W-1:0] t_frac_post;

  logic [MAG_W-1:0]   err_mag, int_mag, derr_mag;
  logic signed [INTW_W-1:0] int_add, int_sum, int_clamped;
  logic [TIME_W:0]    trial;
  logic               qbit;
  logic signed [ACCX_W-1:0] acc_sum;
  logic [ACC_W-1:0]   acc_clamped;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_KP:     prdata = DATA_W'(kp);
      REG_KI:     prdata = DATA_W'(ki);
      REG_KD:     prdata = DATA_W'(kd);
      REG_TARGET: prdata = DATA_W'(target);
    endcase
  end

  assign err_mag  = err[ERR_W-1] ? MAG_W'(-err) : MAG_W'(err);
  assign int_mag  = err_int[ERR_W-1] ? MAG_W'(-err_int) : MAG_W'(err_int);
  assign derr_mag = derr[DERR_W-1] ? MAG_W'(-derr) : MAG_W'(derr);

  // per-term operand select
  always_comb begin
    case (term)
      TERM_P: begin
        t_gain = kp; t_scale = PI_SCALE; t_mag = err_mag;
        t_neg = err[ERR_W-1]; t_div = P_DIVISOR;
        t_pre = P_PRE_SHIFT; t_rcp = P_RCP; t_post = P_RCP_SHIFT;
        t_frac_rcp = P_FRAC_RCP; t_frac_post = P_FRAC_SHIFT;
      end
      TERM_I: begin
        t_gain = ki; t_scale = PI_SCALE; t_mag = int_mag;
        t_neg = err_int[ERR_W-1]; t_div = I_DIVISOR;
        t_pre = I_PRE_SHIFT; t_rcp = I_RCP; t_post = I_RCP_SHIFT;
        t_frac_rcp = I_FRAC_RCP; t_frac_post = I_FRAC_SHIFT;
      end
      TERM_D: begin
        t_gain = kd; t_scale = D_SCALE; t_mag = derr_mag;
        t_neg = derr[DERR_W-1]; t_div = dt;
        t_pre = '0; t_rcp = '0; t_post = '0;
        t_frac_rcp = '0; t_frac_post = '0;
      end
      default: begin
        t_gain = '0; t_scale = '0; t_mag = '0;
        t_neg = 1'b0; t_div = P_DIVISOR;
        t_pre = '0; t_rcp = '0; t_post = '0;
        t_frac_rcp = '0; t_frac_post = '0;
      end
    endcase
  end

  // shared multiplier
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // integral update, full precision then clamp
  assign int_add = err[ERR_W-1] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign int_sum = INTW_W'(err_int) + int_add;
  always_comb begin
    if (int_sum > INT_LIM) begin
      int_clamped = INT_LIM;
    end else if (int_sum < -INT_LIM) begin
      int_clamped = -INT_LIM;
    end else begin
      int_clamped = int_sum;
    end
  end

  // restoring divider step
  assign trial = {rem, num[NUM_W-1]};
  assign qbit  = trial >= {1'b0, divisor};

  assign acc_sum = $signed(ACCX_W'({1'b0, dacc})) + ACCX_W'(sum);
  always_comb begin
    if (acc_sum > $signed(ACCX_W'({1'b0, ACC_MAX}))) begin
      acc_clamped = ACC_MAX;
    end else if (acc_sum < $signed(ACCX_W'({1'b0, ACC_MIN}))) begin
      acc_clamped = ACC_MIN;
    end else begin
      acc_clamped = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CHECK;
      ST_CHECK:     state_next = (dt < TIME_W'(MIN_INTERVAL_MS)) ? ST_EMIT : ST_MUL_INT;
      ST_MUL_INT:   state_next = ST_INTEG;
      ST_INTEG:     state_next = ST_MUL_GAIN;
      ST_MUL_GAIN:  state_next = (term == TERM_D) ? ST_MUL_MAG : ST_RCP_QUO;
      ST_MUL_MAG:   state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV;
      ST_DIV:       if (cnt == CNT_W'(NUM_W - 1)) state_next = ST_ACC;
      ST_RCP_QUO:   state_next = ST_RCP_REM;
      ST_RCP_REM:   state_next = ST_RCP_SCALE;
      ST_RCP_SCALE: state_next = ST_RCP_FRAC;
      ST_RCP_FRAC:  state_next = ST_RCP_WHOLE;
      ST_RCP_WHOLE: state_next = ST_ACC;
      ST_ACC:       state_next = (term == TERM_D) ? ST_FINISH : ST_MUL_GAIN;
      ST_FINISH:    state_next = ST_EMIT;
      ST_EMIT:      if (!out_valid || out_ready) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_IDLE:      in_ready = 1'b1;
      ST_MUL_INT:   begin mul_a = dt;                 mul_b = TIME_W'(err_mag); end
      ST_MUL_GAIN: begin
        mul_a = TIME_W'(t_gain);
        mul_b = (term == TERM_D) ? TIME_W'(t_scale) : TIME_W'(t_mag);
      end
      ST_MUL_MAG:   begin mul_a = prod[TIME_W-1:0];  mul_b = TIME_W'(t_mag);   end
      ST_RCP_QUO:   begin mul_a = prod[TIME_W-1:0] >> t_pre; mul_b = t_rcp;    end
      ST_RCP_REM:   begin mul_a = num[TIME_W-1:0];   mul_b = t_div;            end
      ST_RCP_SCALE: begin mul_a = rem;               mul_b = TIME_W'(t_scale); end
      ST_RCP_FRAC:  begin mul_a = prod[TIME_W-1:0];  mul_b = t_frac_rcp;       end
      ST_RCP_WHOLE: begin mul_a = num[TIME_W-1:0];   mul_b = TIME_W'(t_scale); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      kp        <= KP_RESET;
      ki        <= KI_RESET;
      kd        <= KD_RESET;
      target    <= TARGET_RESET;
      last_time <= '0;
      prev_err  <= '0;
      err_int   <= '0;
      dacc      <= ACC_RESET;
      out_valid <= 1'b0;
      term      <= TERM_P;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_KP:     kp <= pwdata[GAIN_W-1:0];
          REG_KI:     ki <= pwdata[GAIN_W-1:0];
          REG_KD:     kd <= pwdata[GAIN_W-1:0];
          REG_TARGET: begin
            target  <= pwdata[SPEED_W-1:0];
            err_int <= '0;
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now_q <= time_now_ms;
            dt    <= time_now_ms - last_time;
            err   <= $signed({1'b0, target}) - $signed({1'b0, measured_speed});
            upd   <= 1'b0;
          end
        end
        ST_MUL_INT: prod <= mul_p;
        ST_INTEG: begin
          err_int <= int_clamped[ERR_W-1:0];
          derr    <= DERR_W'(err) - DERR_W'(prev_err);
          sum     <= '0;
          term    <= TERM_P;
        end
        ST_MUL_GAIN: begin
          prod <= mul_p;
          neg  <= t_neg;
        end
        ST_MUL_MAG: prod <= mul_p;
        ST_DIV_LOAD: begin
          // round half away from zero on the magnitude
          num     <= NUM_W'(prod) + NUM_W'(t_div >> 1);
          divisor <= t_div;
          rem     <= '0;
          cnt     <= '0;
        end
        ST_DIV: begin
          rem <= qbit ? TIME_W'(trial - {1'b0, divisor}) : trial[TIME_W-1:0];
          num <= {num[NUM_W-2:0], qbit};
          cnt <= cnt + 1'b1;
        end
        // whole quotient of gain*mag over the divisor
        ST_RCP_QUO:   num  <= NUM_W'(mul_p >> t_post);
        ST_RCP_REM:   rem  <= prod[TIME_W-1:0] - mul_p[TIME_W-1:0];
        // scaled remainder plus half divisor, rounded quotient of it
        ST_RCP_SCALE: prod <= mul_p + PROD_W'(t_div >> 1);
        ST_RCP_FRAC:  rem  <= TIME_W'(mul_p >> t_frac_post);
        ST_RCP_WHOLE: num  <= NUM_W'(mul_p) + NUM_W'(rem);
        ST_ACC: begin
          sum  <= neg ? sum - SUM_W'(num) : sum + SUM_W'(num);
          term <= term_t'(term + 1'b1);
        end
        ST_FINISH: begin
          dacc      <= acc_clamped;
          prev_err  <= err;
          last_time <= now_q;
          upd       <= 1'b1;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            duty      <= dacc[ACC_W-1 -: DUTY_W];
            updated   <= upd;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pfsc_checker.sv =====
module pfsc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pfsc_pkg::SPEED_W-1:0] measured_speed,
  input logic [pfsc_pkg::TIME_W-1:0]  time_now_ms,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pfsc_pkg::DUTY_W-1:0]  duty,
  input logic                         updated,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [pfsc_pkg::ADDR_W-1:0]  paddr,
  input logic [pfsc_pkg::DATA_W-1:0]  pwdata,
  input logic [pfsc_pkg::DATA_W-1:0]  prdata,
  input logic                         pready
);
  import pfsc_pkg::*;

  // duty never leaves its clamp window
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty >= DUTY_MIN)
    else $error("duty below minimum");

  // one sample at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while busy");

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(updated))
    else $error("output beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind pid_fan_speed_controller pfsc_checker u_pfsc_checker (.*);

// ===== dv/pid_fan_speed_controller_test.sv =====
`timescale 1ns / 1ps

module pid_fan_speed_controller_test;
  import pfsc_pkg::*;

  typedef enum bit {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    bit [15:0]   value;
    bit [31:0]   ms;
    bit          known;
    bit [7:0]    duty;
    bit          updated;
  } stim_row_t;

  typedef struct {
    bit [DUTY_W-1:0] duty;
    bit              updated;
  } duty_beat_t;

  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, REG_KP,     16'd1500,  32'd5,          1'b1, 8'd128, 1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd0,     32'd9,          1'b1, 8'd128, 1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd1500,  32'd10,         1'b1, 8'd128, 1'b1},
    '{ROW_SAMPLE, REG_KP,     16'd1500,  32'd19,         1'b1, 8'd128, 1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd0,     32'd1000,       1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd65535, 32'd2000,       1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KP,     16'd65535, 32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd0,     32'd3000,       1'b1, 8'd255, 1'b1},
    '{ROW_SAMPLE, REG_KP,     16'd65535, 32'd3005,       1'b1, 8'd255, 1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd65535, 32'd3010,       1'b1, 8'd60,  1'b1},
    '{ROW_WRITE,  REG_TARGET, 16'd65535, 32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd0,     32'd4000,       1'b1, 8'd255, 1'b1},
    '{ROW_WRITE,  REG_TARGET, 16'd0,     32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd65535, 32'd5000,       1'b1, 8'd60,  1'b1},
    '{ROW_WRITE,  REG_KP,     16'd0,     32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KI,     16'd65535, 32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KD,     16'd65535, 32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd40000, 32'd5010,       1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd0,     32'd5030,       1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd100,   32'hFFFF_FFF0,  1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd100,   32'h0000_0005,  1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd100,   32'h0000_0003,  1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KP,     16'd2048,  32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KI,     16'd819,   32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_KD,     16'd205,   32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_WRITE,  REG_TARGET, 16'd1500,  32'd0,          1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, REG_KP,     16'd1500,  32'd20,         1'b0, 8'd0,   1'b0}
  };

  localparam reg_idx_t ALL_REGS [4] = '{REG_KP, REG_KI, REG_KD, REG_TARGET};
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 117;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SPEED_W-1:0]  measured_speed = '0;
  logic [TIME_W-1:0]   time_now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DUTY_W-1:0]   duty;
  logic                updated;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bit [GAIN_W-1:0]   kp_reg;
  bit [GAIN_W-1:0]   ki_reg;
  bit [GAIN_W-1:0]   kd_reg;
  bit [SPEED_W-1:0]  target_reg;
  bit [TIME_W-1:0]   last_update_ms;
  longint            prev_error;
  longint            integral_rpm_ms;
  longint            duty_acc_q16;

  duty_beat_t   pending_duty [$];
  int unsigned  fault_count = 0;
  bit           gaps_on = 1'b1;

  pid_fan_speed_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_speed (measured_speed),
    .time_now_ms    (time_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .duty           (duty),
    .updated        (updated),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void reset_loop();
    kp_reg = KP_RESET;
    ki_reg = KI_RESET;
    kd_reg = KD_RESET;
    target_reg = TARGET_RESET;
    last_update_ms = '0;
    prev_error = 0;
    integral_rpm_ms = 0;
    duty_acc_q16 = ACC_RESET;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic duty_beat_t next_duty(bit [SPEED_W-1:0] meas, bit [TIME_W-1:0] now_ms);
    duty_beat_t beat;
    bit [TIME_W-1:0] dt;
    longint dt_l, err, de, sum, lim, acc_lo, acc_hi;
    longint kp, ki, kd, pi_k, d_k, p_div, i_div;
    dt = now_ms - last_update_ms;
    dt_l = dt;
    lim = INTEGRAL_LIMIT_RPM_MS_DEF;
    acc_lo = ACC_MIN;
    acc_hi = ACC_MAX;
    kp = kp_reg;
    ki = ki_reg;
    kd = kd_reg;
    pi_k = PI_SCALE;
    d_k = D_SCALE;
    p_div = P_DIVISOR;
    i_div = I_DIVISOR;
    if (dt < MIN_INTERVAL_MS_DEF) begin
      beat.duty = DUTY_W'(duty_acc_q16 >>> 16);
      beat.updated = 1'b0;
      return beat;
    end
    err = longint'(target_reg) - longint'(meas);
    integral_rpm_ms = integral_rpm_ms + err * dt_l;
    if (integral_rpm_ms > lim) integral_rpm_ms = lim;
    if (integral_rpm_ms < -lim) integral_rpm_ms = -lim;
    de = err - prev_error;
    sum = div_nearest(kp * err * pi_k, p_div);
    sum += div_nearest(ki * integral_rpm_ms * pi_k, i_div);
    if (dt_l != 0) sum += div_nearest(kd * de * d_k, dt_l);
    duty_acc_q16 = duty_acc_q16 + sum;
    if (duty_acc_q16 > acc_hi) duty_acc_q16 = acc_hi;
    if (duty_acc_q16 < acc_lo) duty_acc_q16 = acc_lo;
    prev_error = err;
    last_update_ms = now_ms;
    beat.duty = DUTY_W'(duty_acc_q16 >>> 16);
    beat.updated = 1'b1;
    return beat;
  endfunction

  function automatic bit [15:0] gain_or_target(reg_idx_t idx);
    case (idx)
      REG_KP: return kp_reg;
      REG_KI: return ki_reg;
      REG_KD: return kd_reg;
      default: return target_reg;
    endcase
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic bit [15:0] pick_reg_value(reg_idx_t idx);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: begin
        if (idx == REG_TARGET) return 16'($urandom_range(300, 6000));
        return 16'($urandom_range(0, 8191));
      end
    endcase
  endfunction

  task automatic check_register(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    want = {16'b0, gain_or_target(idx)};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %s read expected %0d actual %0d", $time, idx.name(), want, prdata);
      fault_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(reg_idx_t idx, bit [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KP: kp_reg = value;
      REG_KI: ki_reg = value;
      REG_KD: kd_reg = value;
      default: begin
        target_reg = value;
        integral_rpm_ms = 0;
      end
    endcase
    @(posedge clk);
    check_register(idx);
  endtask

  task automatic send_sample(bit [15:0] meas, bit [31:0] now_ms, bit known,
                             bit [7:0] known_duty, bit known_updated);
    int unsigned gap;
    duty_beat_t beat;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_speed <= meas;
    time_now_ms <= now_ms;
    do @(posedge clk); while (!in_ready);
    beat = next_duty(meas, now_ms);
    if (known) begin
      beat.duty = known_duty;
      beat.updated = known_updated;
    end
    pending_duty.push_back(beat);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk);
  endtask

  initial begin : sink_pacing
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 400)) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
      out_ready <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    duty_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_duty.size() == 0) begin
        $display("%0t: unexpected beat duty %0d updated %0b", $time, duty, updated);
        fault_count++;
      end else begin
        want = pending_duty.pop_front();
        if (duty !== want.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, want.duty, duty);
          fault_count++;
        end
        if (updated !== want.updated) begin
          $display("%0t: updated expected %0b actual %0b", $time, want.updated, updated);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    bit [31:0] now_ms;
    bit [15:0] meas;
    int off;
    int level;
    int unsigned r;
    reset_loop();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (ALL_REGS[k]) check_register(ALL_REGS[k]);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        set_register(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        send_sample(DIRECTED[i].value, DIRECTED[i].ms, DIRECTED[i].known,
                    DIRECTED[i].duty, DIRECTED[i].updated);
      end
    end

    now_ms = 32'd40;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      gaps_on = (phase % 3 != 1);
      foreach (ALL_REGS[k]) begin
        if ($urandom_range(0, 1) == 1) set_register(ALL_REGS[k], pick_reg_value(ALL_REGS[k]));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          meas = 16'($urandom);
        end else begin
          off = $urandom_range(0, 800);
          level = int'(target_reg) + off - 400;
          if (level < 0) level = 0;
          if (level > 65535) level = 65535;
          meas = 16'(level);
        end
        r = $urandom_range(0, 63);
        if (r == 0) now_ms = $urandom;
        else if (r == 1) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
        else if (r < 10) now_ms = now_ms + $urandom_range(0, 9);
        else now_ms = now_ms + $urandom_range(10, 120);
        send_sample(meas, now_ms, 1'b0, 8'd0, 1'b0);
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
